FILE: src/swsm_pkg.sv
package swsm_pkg;

	typedef logic signed [31:0] data_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_PICK,
		ST_EMIT
	} state_t;

endpackage

FILE: src/swsm_cell.sv
module swsm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  swsm_pkg::data_t in_val,
	input  logic          in_vld,
	input  swsm_pkg::data_t right_val,
	input  logic          right_vld,
	output swsm_pkg::data_t val,
	output logic          vld,
	output swsm_pkg::data_t car_val,
	output logic          car_vld
);
	import swsm_pkg::*;

	data_t val_q;
	logic  vld_q;
	data_t car_val_q;
	logic  car_vld_q;

	// keep the smaller value, pass the larger one to the right; on shift, take the right neighbour's value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= 1'b0;
			car_vld_q <= 1'b0;
		end else if (shift) begin
			vld_q     <= right_vld;
			car_vld_q <= 1'b0;
		end else begin
			car_vld_q <= in_vld && vld_q;
			if (in_vld && !vld_q) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= right_val;
		end else if (in_vld) begin
			if (!vld_q) begin
				val_q <= in_val;
			end else if (in_val < val_q) begin
				val_q     <= in_val;
				car_val_q <= val_q;
			end else begin
				car_val_q <= in_val;
			end
		end
	end

	assign val     = val_q;
	assign vld     = vld_q;
	assign car_val = car_val_q;
	assign car_vld = car_vld_q;

endmodule

FILE: src/sort_with_second_max_min.sv
// After the item marked last, the block waits in ST_SETTLE for the insertion wave to reach
// the far end of the cell row, picks the second max/min in ST_PICK, then emits in ST_EMIT.
// Throughput: one item in per cycle while loading; one result out per cycle while emitting
// and result_stall is low. No new item is taken until the whole set has been emitted.
// Reset (arst_n low, asynchronous) empties every cell, clears count and overflow flag,
// and drops any pending result.
module sort_with_second_max_min #(
	parameter int MAX_ITEMS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  swsm_pkg::data_t value,
	input  logic            last,
	output logic            result_valid,
	input  logic            result_stall,
	output swsm_pkg::data_t sorted_value,
	output swsm_pkg::data_t second_max,
	output swsm_pkg::data_t second_min,
	output logic            too_few,
	output logic            overflowed,
	output logic            last_out
);
	import swsm_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W = $clog2(MAX_ITEMS);

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [IDX_W-1:0] timer_q;
	logic             ovf_q;

	data_t smax_q, smin_q;
	logic  few_q;

	// result register
	logic  res_vld_q;
	data_t res_val_q, res_smax_q, res_smin_q;
	logic  res_few_q, res_ovf_q, res_last_q;

	// cell row: chain_* [i] feeds cell i, cell i drives chain_* [i+1]
	data_t chain_val [MAX_ITEMS+1];
	logic  chain_vld [MAX_ITEMS+1];
	data_t cell_val  [MAX_ITEMS];
	logic  cell_vld  [MAX_ITEMS];

	logic accept, insert, load_res, shift;
	logic [CNT_W-1:0] idx_full;
	logic [IDX_W-1:0] smax_idx;

	assign accept   = item_valid && !item_stall;
	assign insert   = accept && (cnt_q < CNT_W'(MAX_ITEMS));
	assign load_res = (state_q == ST_EMIT) && (!res_vld_q || !result_stall);
	assign shift    = load_res;

	// position count-2 of the sorted set, only used when count >= 2
	assign idx_full = cnt_q - CNT_W'(2);
	assign smax_idx = idx_full[IDX_W-1:0];

	assign chain_val[0] = value;
	assign chain_vld[0] = insert;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		data_t r_val;
		logic  r_vld;
		if (i == MAX_ITEMS - 1) begin : g_end
			assign r_val = '0;
			assign r_vld = 1'b0;
		end else begin : g_mid
			assign r_val = cell_val[i+1];
			assign r_vld = cell_vld[i+1];
		end
		swsm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.in_val    (chain_val[i]),
			.in_vld    (chain_vld[i]),
			.right_val (r_val),
			.right_vld (r_vld),
			.val       (cell_val[i]),
			.vld       (cell_vld[i]),
			.car_val   (chain_val[i+1]),
			.car_vld   (chain_vld[i+1])
		);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and input stall
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		unique case (state_q)
			ST_LOAD: begin
				item_stall = 1'b0;
				if (accept && last) state_d = ST_SETTLE;
			end
			ST_SETTLE: begin
				if (timer_q == IDX_W'(MAX_ITEMS - 1)) state_d = ST_PICK;
			end
			ST_PICK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_res && rem_q == CNT_W'(1)) state_d = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// count, overflow, settle timer, remaining results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			timer_q <= '0;
			rem_q   <= '0;
		end else begin
			if (insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (accept) begin
				ovf_q <= 1'b1;
			end
			// hold the timer at zero outside the settle window
			if (state_q == ST_SETTLE) begin
				timer_q <= timer_q + IDX_W'(1);
			end else begin
				timer_q <= '0;
			end
			if (state_q == ST_PICK) begin
				rem_q <= cnt_q;
			end else if (load_res) begin
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// grab the second smallest and second largest once the row has settled
	always_ff @(posedge clk) begin
		if (state_q == ST_PICK) begin
			if (cnt_q < CNT_W'(2)) begin
				few_q  <= 1'b1;
				smax_q <= '0;
				smin_q <= '0;
			end else begin
				few_q  <= 1'b0;
				smax_q <= cell_val[smax_idx];
				smin_q <= cell_val[1];
			end
		end
	end

	// result register: advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (load_res) begin
			res_vld_q <= 1'b1;
		end else if (!result_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_val_q  <= cell_val[0];
			res_smax_q <= smax_q;
			res_smin_q <= smin_q;
			res_few_q  <= few_q;
			res_ovf_q  <= ovf_q;
			res_last_q <= (rem_q == CNT_W'(1));
		end
	end

	assign result_valid = res_vld_q;
	assign sorted_value = res_val_q;
	assign second_max   = res_smax_q;
	assign second_min   = res_smin_q;
	assign too_few      = res_few_q;
	assign overflowed   = res_ovf_q;
	assign last_out     = res_last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!chain_vld[MAX_ITEMS])
		else $error("value pushed off the end of the cell row");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && rem_q != '0) |-> cell_vld[0])
		else $error("emitting from an empty cell");

	a_few_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && too_few) |-> last_out)
		else $error("too-few result is not the last of its run");

endmodule
